// ===== rtl/core/weighted_round_robin_picker_assert.svh =====
// ----------------------------------------------------------------------------
// weighted_round_robin_picker_assert.svh
// Assertion macros shared by the picker RTL. clk and rst_n must be in scope.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_ROUND_ROBIN_PICKER_ASSERT_SVH
`define WEIGHTED_ROUND_ROBIN_PICKER_ASSERT_SVH

// condition holds at every edge out of reset
`define WRR_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define WRR_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define WRR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/wrr_pkg.sv =====
// ----------------------------------------------------------------------------
// wrr_pkg
// Types and constants of the weighted round-robin picker.
// ----------------------------------------------------------------------------
package wrr_pkg;

    localparam int MAX_ENTRIES   = 16;
    localparam int FRACTION_BITS = 8;

    localparam int ENTRY_W  = 4;
    localparam int COUNT_W  = 5;
    localparam int WEIGHT_W = 16;
    localparam int MASK_W   = 16;

    localparam int RCNT_W = FRACTION_BITS + 1;
    localparam int USED_W = RCNT_W + FRACTION_BITS;
    localparam int C1_W   = RCNT_W + 1;
    localparam int D_W    = FRACTION_BITS + 1;
    localparam int PROD_W = C1_W + D_W;

    localparam logic [WEIGHT_W-1:0] ONE_FX     = WEIGHT_W'(1) << FRACTION_BITS;
    localparam logic [PROD_W-1:0]   TWO_ONE_FX = PROD_W'(2) << FRACTION_BITS;

    typedef enum logic
    {
        OP_PICK = 1'b0,
        OP_LOAD = 1'b1
    } opcode_t;

    typedef struct packed
    {
        opcode_t             opcode;
        logic [ENTRY_W-1:0]  entry_index;
        logic [WEIGHT_W-1:0] weight_value;
        logic [MASK_W-1:0]   available_mask;
    } item_t;

    typedef struct packed
    {
        logic [ENTRY_W-1:0] chosen_index;
        logic               fallback;
    } result_t;

    typedef enum logic [2:0]
    {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

endpackage

// ===== rtl/core/wrr_chan_if.sv =====
// ----------------------------------------------------------------------------
// wrr_chan_if
// Valid/ready channels of the picker: one for input items, one for results.
// ----------------------------------------------------------------------------
interface wrr_item_if import wrr_pkg::*; ();

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

interface wrr_result_if import wrr_pkg::*; ();

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

// ===== rtl/core/weighted_round_robin_picker.sv =====
// ----------------------------------------------------------------------------
// weighted_round_robin_picker
// A load beat stores one entry's 8.8 weight and returns nothing. A pick
// beat scans the entries in use one per cycle from the rotation pointer,
// wrapping round, through one shared multiply-compare unit that tests each
// available entry's weight rule and updates its counters; the first entry
// that passes is returned, else the pointer entry with the fallback flag.
// Input ready stays low from the accepted pick through the scan until its
// result moves into the output register, where it waits, so the next beat
// can be taken meanwhile; a pick that finishes while an earlier result
// still waits there holds until that result is taken.
// ----------------------------------------------------------------------------
`include "weighted_round_robin_picker_assert.svh"

module weighted_round_robin_picker import wrr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    wrr_item_if.sink           item,
    wrr_result_if.source       result
);

    state_t state_reg, state_next;

    logic [WEIGHT_W-1:0] weight_reg [MAX_ENTRIES];
    logic [RCNT_W-1:0]   run_reg    [MAX_ENTRIES];
    logic [RCNT_W-1:0]   frac_reg   [MAX_ENTRIES];

    logic [COUNT_W-1:0] ptr_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [ENTRY_W-1:0] idx_reg;
    logic [ENTRY_W-1:0] start_reg;
    logic [COUNT_W-1:0] steps_reg;
    logic [COUNT_W-1:0] nuse_reg;
    logic [MASK_W-1:0]  mask_reg;

    logic [ENTRY_W-1:0] res_idx_reg;
    logic               res_fb_reg;

    logic    out_valid_reg;
    result_t out_data_reg;

    logic item_fire;
    logic out_free;

    logic [COUNT_W-1:0] n_clamp;
    logic [ENTRY_W-1:0] start_val;

    // per-entry step
    logic [WEIGHT_W-1:0]      w;
    logic [RCNT_W-1:0]        rc;
    logic [RCNT_W-1:0]        fc;
    logic                     avail;
    logic [USED_W-1:0]        used;
    logic [WEIGHT_W-1:0]      left;
    logic [RCNT_W-1:0]        rc_inc;
    logic [RCNT_W-1:0]        fc_inc;
    logic                     w_big;
    logic [FRACTION_BITS-1:0] div_x;
    logic [RCNT_W-1:0]        div_c;
    logic [PROD_W-1:0]        prod;
    logic [PROD_W-1:0]        num;
    logic                     hit;
    logic                     pass;
    logic [RCNT_W-1:0]        rc_new;
    logic [RCNT_W-1:0]        fc_new;
    logic [COUNT_W-1:0]       idx_plus;
    logic                     last_step;

    assign item_fire = item.valid && item.ready;
    assign item.ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || result.ready;

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    always_comb
    begin
        if (count_reg == '0)
        begin
            n_clamp = COUNT_W'(1);
        end
        else if (count_reg > COUNT_W'(MAX_ENTRIES))
        begin
            n_clamp = COUNT_W'(MAX_ENTRIES);
        end
        else
        begin
            n_clamp = count_reg;
        end
        start_val = (ptr_reg >= n_clamp) ? '0 : ptr_reg[ENTRY_W-1:0];
    end

    // shared multiply-compare: counter >= round(ONE / x)
    always_comb
    begin
        w      = weight_reg[idx_reg];
        rc     = run_reg[idx_reg];
        fc     = frac_reg[idx_reg];
        avail  = mask_reg[idx_reg];
        used   = {rc, {FRACTION_BITS{1'b0}}};
        left   = w - used[WEIGHT_W-1:0];
        rc_inc = rc + RCNT_W'(1);
        fc_inc = fc + RCNT_W'(1);
        w_big  = (w > ONE_FX);
        div_x  = w_big ? left[FRACTION_BITS-1:0] : w[FRACTION_BITS-1:0];
        div_c  = w_big ? fc_inc : rc_inc;
        prod   = PROD_W'(C1_W'(div_c) + C1_W'(1)) * PROD_W'({div_x, 1'b0});
        num    = TWO_ONE_FX + PROD_W'(div_x);
        hit    = (prod > num);

        pass   = 1'b0;
        rc_new = rc;
        fc_new = fc;
        if (!avail)
        begin
            pass = 1'b0;
        end
        else if ((w == '0) || (w == ONE_FX))
        begin
            pass = 1'b1;
        end
        else if (w_big)
        begin
            if (used >= USED_W'(w))
            begin
                rc_new = '0;
            end
            else if (left > ONE_FX)
            begin
                rc_new = rc_inc;
                pass   = 1'b1;
            end
            else if (left == ONE_FX)
            begin
                rc_new = '0;
                pass   = 1'b1;
            end
            else
            begin
                rc_new = '0;
                if (hit)
                begin
                    fc_new = '0;
                    pass   = 1'b1;
                end
                else
                begin
                    fc_new = fc_inc;
                end
            end
        end
        else
        begin
            if (hit)
            begin
                rc_new = '0;
                pass   = 1'b1;
            end
            else
            begin
                rc_new = rc_inc;
            end
        end

        idx_plus  = COUNT_W'(idx_reg) + COUNT_W'(1);
        last_step = (steps_reg == nuse_reg - COUNT_W'(1));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire && (item.data.opcode == OP_PICK))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (pass || last_step)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            count_reg     <= COUNT_W'(1);
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                weight_reg[i] <= '0;
                run_reg[i]    <= '0;
                frac_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end

            if (item_fire && (item.data.opcode == OP_LOAD))
            begin
                weight_reg[item.data.entry_index] <= item.data.weight_value;
                run_reg[item.data.entry_index]    <= '0;
                frac_reg[item.data.entry_index]   <= '0;
                ptr_reg                           <= '0;
            end

            if (state_reg == ST_SCAN)
            begin
                run_reg[idx_reg]  <= rc_new;
                frac_reg[idx_reg] <= fc_new;
                if (pass)
                begin
                    ptr_reg <= (rc_new != '0) ? COUNT_W'(idx_reg) : idx_plus;
                end
                else if (last_step)
                begin
                    ptr_reg <= COUNT_W'(start_reg) + COUNT_W'(1);
                end
            end

            if ((state_reg == ST_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.valid && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire && (item.data.opcode == OP_PICK))
        begin
            idx_reg   <= start_val;
            start_reg <= start_val;
            steps_reg <= '0;
            nuse_reg  <= n_clamp;
            mask_reg  <= item.data.available_mask;
        end
        else if (state_reg == ST_SCAN)
        begin
            if (pass)
            begin
                res_idx_reg <= idx_reg;
                res_fb_reg  <= 1'b0;
            end
            else if (last_step)
            begin
                res_idx_reg <= start_reg;
                res_fb_reg  <= 1'b1;
            end
            else
            begin
                idx_reg   <= (idx_plus == nuse_reg) ? '0 : idx_plus[ENTRY_W-1:0];
                steps_reg <= steps_reg + COUNT_W'(1);
            end
        end

        if ((state_reg == ST_EMIT) && out_free)
        begin
            out_data_reg.chosen_index <= res_idx_reg;
            out_data_reg.fallback     <= res_fb_reg;
        end
    end

    `WRR_ASSERT_IMPLIES(a_scan_idx, state_reg == ST_SCAN,
        COUNT_W'(idx_reg) < nuse_reg, "scan index beyond entries in use")
    `WRR_ASSERT_IMPLIES(a_scan_steps, state_reg == ST_SCAN,
        steps_reg < nuse_reg, "scan ran past entries in use")
    `WRR_ASSERT_HOLDS(a_ptr_range, ptr_reg <= COUNT_W'(MAX_ENTRIES),
        "rotation pointer out of range")
    `WRR_ASSERT_NEXT(a_emit_drain, (state_reg == ST_EMIT) && !out_valid_reg,
        out_valid_reg && (state_reg == ST_IDLE), "finished pick not moved to output register")

endmodule
